FILE: design/hsw_pkg.sv
// Package for the int8 hard-swish activation block.
// Holds register indexes, reset values and the fixed-point helper functions.
// No dependencies.
package hsw_pkg;

  typedef logic signed [15:0] q16_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_IN_ZP    = 3'd0;
  localparam logic [2:0] CFG_OUT_ZP   = 3'd1;
  localparam logic [2:0] CFG_OUT_MUL  = 3'd2;
  localparam logic [2:0] CFG_OUT_SH   = 3'd3;
  localparam logic [2:0] CFG_GATE_MUL = 3'd4;
  localparam logic [2:0] CFG_GATE_SH  = 3'd5;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  localparam logic [14:0] MUL_RESET = 15'd16384;

  // Number of register stages between input and output.
  localparam int unsigned NUM_STAGES = 7;

  // Saturating left shift of an int16 value by 0..31.
  function automatic q16_t sat_shl16(input q16_t x, input logic [4:0] s);
    logic signed [47:0] w;
    w = $signed({{32{x[15]}}, x}) <<< s;
    if (w > 48'sd32767) begin
      return 16'sh7fff;
    end else if (w < -48'sd32768) begin
      return 16'sh8000;
    end else begin
      return w[15:0];
    end
  endfunction

  // Rounding right shift by 1..32, ties away from zero.
  function automatic q16_t round_shr16(input q16_t x, input logic [5:0] e);
    logic signed [33:0] xe;
    logic signed [33:0] half;
    logic signed [33:0] t;
    xe   = $signed({{18{x[15]}}, x});
    half = 34'sd1 <<< (e - 6'd1);
    t    = xe + half - $signed({33'd0, x[15]});
    t    = t >>> e;
    return t[15:0];
  endfunction

  // Q15 rounding (half up) of a product whose result is known to fit in int16.
  function automatic q16_t rnd_q15(input logic signed [31:0] p);
    logic signed [31:0] t;
    t = p + 32'sd16384;
    return t[30:15];
  endfunction

  function automatic logic signed [7:0] sat8(input logic signed [16:0] v);
    if (v > 17'sd127) begin
      return 8'sh7f;
    end else if (v < -17'sd128) begin
      return 8'sh80;
    end else begin
      return v[7:0];
    end
  endfunction

endpackage

FILE: design/int8_hardswish_activation_top.sv
// Top level of the int8 hard-swish activation block.
// Seven-stage pipeline with per-stage valid bits; uses hsw_pkg.
//
// Usage:
// The input channel (in_valid/in_ready) carries one int8 activation and a
// last flag per item; the output channel (out_valid/out_ready) returns the
// hard-swish result and the same last flag. Configuration is written through
// cfg_we/cfg_index/cfg_wdata while no item is in flight; writes to indexes
// above five are ignored.
// An accepted item passes through all seven register stages before out_valid
// rises for it. One item is accepted every cycle while out_ready does not stall
// the pipeline; the rate is set by the single pipeline of three 16x16
// multipliers, each followed by a register stage.
// Every stage advances when it is empty or the stage after it advances, so
// bubbles close up during a stall. When out_ready is low with all seven
// stages full, in_ready drops; nothing is lost or repeated.
// A synchronous active-low reset empties the pipeline and loads the register
// reset values (both zero points and shifts zero, both multipliers 16384).
module int8_hardswish_activation_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [7:0]                    in_sample_in,
  input  logic                                 in_last_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [7:0]                    out_sample_out,
  output logic                                 out_last_out,
  input  logic                                 cfg_we,
  input  logic [hsw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [hsw_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import hsw_pkg::*;

  // Configuration registers.
  logic signed [7:0] in_zp_r;
  logic signed [7:0] out_zp_r;
  logic [14:0]       out_mul_r;
  logic signed [5:0] out_sh_r;
  logic [14:0]       gate_mul_r;
  logic signed [5:0] gate_sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_zp_r    <= '0;
      out_zp_r   <= '0;
      out_mul_r  <= MUL_RESET;
      out_sh_r   <= '0;
      gate_mul_r <= MUL_RESET;
      gate_sh_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IN_ZP:    in_zp_r    <= cfg_wdata[7:0];
        CFG_OUT_ZP:   out_zp_r   <= cfg_wdata[7:0];
        CFG_OUT_MUL:  out_mul_r  <= cfg_wdata[14:0];
        CFG_OUT_SH:   out_sh_r   <= cfg_wdata[5:0];
        CFG_GATE_MUL: gate_mul_r <= cfg_wdata[14:0];
        CFG_GATE_SH:  gate_sh_r  <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // Stage control.
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] last_r;
  logic [NUM_STAGES:0]   en;

  always_comb begin
    en[NUM_STAGES] = out_ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      last_r[0] <= in_last_in;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        last_r[k] <= last_r[k-1];
      end
    end
  end

  // Datapath registers.
  q16_t               hires_r;
  logic signed [31:0] pprod_r;
  q16_t               gsh_r;
  q16_t               pre_r;
  logic signed [31:0] gprod_r;
  q16_t               pre3_r;
  logic [14:0]        gate_r;
  logic signed [31:0] fprod_r;
  q16_t               fsh_r;
  logic signed [7:0]  sample_r;

  logic signed [8:0]  diff;
  q16_t               hires_nxt;
  logic signed [31:0] pprod_nxt;
  q16_t               gsh_nxt;
  q16_t               pre_nxt;
  logic signed [31:0] gprod_nxt;
  q16_t               gmul_q;
  q16_t               gpost;
  logic [14:0]        gate_nxt;
  logic signed [31:0] fprod_nxt;
  q16_t               fin;
  q16_t               fsh_nxt;
  logic signed [7:0]  sample_nxt;

  always_comb begin
    // The offset input shifted by seven always fits in int16.
    diff      = $signed({in_sample_in[7], in_sample_in}) - $signed({in_zp_r[7], in_zp_r});
    hires_nxt = $signed({diff, 7'd0});

    pprod_nxt = hires_r * $signed({1'b0, out_mul_r});
    if (gate_sh_r > 6'sd0) begin
      gsh_nxt = sat_shl16(hires_r, 5'(gate_sh_r - 6'sd1));
    end else begin
      gsh_nxt = hires_r;
    end

    pre_nxt   = rnd_q15(pprod_r);
    gprod_nxt = gsh_r * $signed({1'b0, gate_mul_r});

    gmul_q = rnd_q15(gprod_r);
    priority if (gate_sh_r > 6'sd0) begin
      gpost = sat_shl16(gmul_q, 5'd1);
    end else if (gate_sh_r < 6'sd0) begin
      gpost = round_shr16(gmul_q, 6'(-gate_sh_r));
    end else begin
      gpost = gmul_q;
    end
    // Adding 32768 flips the sign bit; the halving drops bit zero.
    gate_nxt = {~gpost[15], gpost[14:1]};

    fprod_nxt = $signed({1'b0, gate_r}) * pre3_r;

    fin = rnd_q15(fprod_r);
    if (out_sh_r < 6'sd0) begin
      fsh_nxt = round_shr16(fin, 6'(-out_sh_r));
    end else begin
      fsh_nxt = sat_shl16(fin, out_sh_r[4:0]);
    end

    sample_nxt = sat8($signed({fsh_r[15], fsh_r}) + $signed({{9{out_zp_r[7]}}, out_zp_r}));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hires_r <= hires_nxt;
    end
    if (en[1]) begin
      pprod_r <= pprod_nxt;
      gsh_r   <= gsh_nxt;
    end
    if (en[2]) begin
      pre_r   <= pre_nxt;
      gprod_r <= gprod_nxt;
    end
    if (en[3]) begin
      pre3_r <= pre_r;
      gate_r <= gate_nxt;
    end
    if (en[4]) begin
      fprod_r <= fprod_nxt;
    end
    if (en[5]) begin
      fsh_r <= fsh_nxt;
    end
    if (en[6]) begin
      sample_r <= sample_nxt;
    end
  end

  assign out_valid      = vld_r[NUM_STAGES-1];
  assign out_sample_out = sample_r;
  assign out_last_out   = last_r[NUM_STAGES-1];

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("accepted item did not reach the first stage");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ((&vld_r) && !out_ready) |-> !in_ready)
    else $error("full pipeline accepted an item during a stall");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[3] && !en[3]) |=> (vld_r[3] && $stable(gate_r) && $stable(pre3_r)))
    else $error("stalled gate stage lost or changed its item");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(vld_r[NUM_STAGES-2]))
    else $error("result appeared without an item in the stage before it");
`endif

endmodule

FILE: tb/int8_hardswish_activation_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for int8_hardswish_activation_top.
// Drives random and directed activations under varied register settings and
// checks every result against a bit-accurate hard-swish predictor; uses hsw_pkg.
module int8_hardswish_activation_top_tb;

  localparam logic [hsw_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [hsw_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned ITEMS_PER_SETTING = 66;

  typedef struct packed {
    logic signed [7:0] data;
    logic              tlast;
  } hsw_result_t;

  class hsw_scoreboard;
    logic signed [7:0] in_zp;
    logic signed [7:0] out_zp;
    logic [14:0]       out_mul;
    logic signed [5:0] out_sh;
    logic [14:0]       gate_mul;
    logic signed [5:0] gate_sh;
    hsw_result_t       pending_results[$];
    int unsigned       mismatches;

    function new();
      in_zp      = 8'sd0;
      out_zp     = 8'sd0;
      out_mul    = hsw_pkg::MUL_RESET;
      out_sh     = 6'sd0;
      gate_mul   = hsw_pkg::MUL_RESET;
      gate_sh    = 6'sd0;
      mismatches = 0;
    endfunction

    // Only the low bits of each register survive; spare indexes do nothing.
    function void write_reg(logic [hsw_pkg::CFG_IDX_W-1:0] idx,
                            logic [hsw_pkg::CFG_DATA_W-1:0] wdata);
      case (idx)
        hsw_pkg::CFG_IN_ZP:    in_zp    = wdata[7:0];
        hsw_pkg::CFG_OUT_ZP:   out_zp   = wdata[7:0];
        hsw_pkg::CFG_OUT_MUL:  out_mul  = wdata[14:0];
        hsw_pkg::CFG_OUT_SH:   out_sh   = wdata[5:0];
        hsw_pkg::CFG_GATE_MUL: gate_mul = wdata[14:0];
        hsw_pkg::CFG_GATE_SH:  gate_sh  = wdata[5:0];
        default: ;
      endcase
    endfunction

    function longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint q15_mul(longint a, longint b);
      if (a == -32768 && b == -32768) return 32767;
      return sat16((a * b + 16384) >>> 15);
    endfunction

    function longint shl_sat(longint x, int s);
      return sat16(x <<< s);
    endfunction

    // Ties go away from zero: negative values need one more in the remainder.
    function longint shr_round(longint x, int e);
      longint mask;
      longint rem;
      longint thr;
      mask = (64'sd1 <<< e) - 1;
      rem  = x & mask;
      thr  = (mask >>> 1) + ((x < 0) ? 1 : 0);
      return sat16((x >>> e) + ((rem > thr) ? 1 : 0));
    endfunction

    function logic signed [7:0] hardswish(logic signed [7:0] act);
      longint x;
      longint hires;
      longint pre;
      longint g;
      longint fin;
      int     gs;
      int     os;
      gs    = gate_sh;
      os    = out_sh;
      x     = act;
      hires = shl_sat(sat16(x - in_zp), 7);
      pre   = q15_mul(hires, longint'(out_mul));
      g     = hires;
      if (gs > 0) g = shl_sat(g, gs - 1);
      g = q15_mul(g, longint'(gate_mul));
      if (gs > 0) begin
        g = shl_sat(g, 1);
      end else if (gs < 0) begin
        g = shr_round(g, -gs);
      end
      g   = (g + 32768) >>> 1;
      fin = q15_mul(g, pre);
      if (os < 0) begin
        fin = shr_round(fin, -os);
      end else begin
        fin = shl_sat(fin, os);
      end
      fin = fin + out_zp;
      if (fin > 127) return 8'sh7f;
      if (fin < -128) return 8'sh80;
      return fin[7:0];
    endfunction

    function void note_input(logic signed [7:0] act, logic tlast);
      hsw_result_t r;
      r.data  = hardswish(act);
      r.tlast = tlast;
      pending_results.push_back(r);
    endfunction

    function void check_result(logic signed [7:0] act, logic tlast);
      hsw_result_t r;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending: sample_out %0d last_out %0b",
                 $time, act, tlast);
        mismatches++;
        return;
      end
      r = pending_results.pop_front();
      if (r.data !== act) begin
        $display("%0t: sample_out expected %0d, actual %0d", $time, r.data, act);
        mismatches++;
      end
      if (r.tlast !== tlast) begin
        $display("%0t: last_out expected %0b, actual %0b", $time, r.tlast, tlast);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic signed [7:0]                  in_sample_in = 8'sd0;
  logic                               in_last_in = 1'b0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [7:0]                  out_sample_out;
  logic                               out_last_out;
  logic                               cfg_we = 1'b0;
  logic [hsw_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [hsw_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;

  hsw_scoreboard sb;

  int8_hardswish_activation_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_in  (in_sample_in),
    .in_last_in    (in_last_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .out_last_out  (out_last_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_sample_out, out_last_out);
    end
  end

  // Called and returns at a falling edge.
  task automatic send_item(input logic signed [7:0] act, input logic tlast);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_sample_in = act;
    in_last_in   = tlast;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(act, tlast);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [hsw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hsw_pkg::CFG_DATA_W-1:0] wdata);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = wdata;
    @(posedge clk);
    sb.write_reg(idx, wdata);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Fills the bits above the register width with noise.
  function automatic logic [14:0] with_junk(int val, int width);
    logic [14:0] mask;
    mask = (15'h1 << width) - 15'h1;
    return (15'($urandom) & ~mask) | (15'(val) & mask);
  endfunction

  task automatic load_config(input int izp, input int ozp, input int omul,
                             input int osh, input int gmul, input int gsh);
    write_reg(hsw_pkg::CFG_IN_ZP, with_junk(izp, 8));
    write_reg(hsw_pkg::CFG_OUT_ZP, with_junk(ozp, 8));
    write_reg(hsw_pkg::CFG_OUT_MUL, with_junk(omul, 15));
    write_reg(hsw_pkg::CFG_OUT_SH, with_junk(osh, 6));
    write_reg(hsw_pkg::CFG_GATE_MUL, with_junk(gmul, 15));
    write_reg(hsw_pkg::CFG_GATE_SH, with_junk(gsh, 6));
    write_reg(CFG_SPARE_A, 15'($urandom));
    write_reg(CFG_SPARE_B, 15'($urandom));
  endtask

  // The whole pipeline has to be empty before the registers change.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (hsw_pkg::NUM_STAGES + 2) @(negedge clk);
  endtask

  // Mostly modest exponents, so that results do not just saturate.
  function automatic int pick_shift();
    if ($urandom_range(1) == 0) return int'($urandom_range(9)) - 6;
    return int'($urandom_range(63)) - 32;
  endfunction

  initial begin
    int phase;
    int seg;
    int n;
    sb = new();
    send_idle_pct = 22;
    recv_idle_pct = 57;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: field extremes and a few small values.
    send_item(-8'sd128, 1'b0);
    send_item(8'sd127, 1'b1);
    send_item(8'sd0, 1'b0);
    send_item(8'sd1, 1'b1);
    send_item(-8'sd1, 1'b0);
    send_item(8'sd3, 1'b0);
    send_item(-8'sd3, 1'b1);
    send_item(8'sd100, 1'b0);
    drain();
    // Both exponents at -32: a right shift by thirty-two clears the value.
    load_config(0, 0, 16384, -32, 16384, -32);
    send_item(-8'sd128, 1'b1);
    send_item(8'sd127, 1'b0);
    send_item(8'sd5, 1'b1);
    drain();
    // Left-shift paths with saturation.
    load_config(127, -128, 20000, 2, 30000, 3);
    send_item(-8'sd128, 1'b0);
    send_item(8'sd127, 1'b1);
    send_item(8'sd0, 1'b0);
    send_item(-8'sd1, 1'b1);
    drain();
    // Rounding right-shift paths with the largest multipliers.
    load_config(-128, 127, 32767, -3, 32767, -5);
    send_item(-8'sd128, 1'b1);
    send_item(8'sd127, 1'b0);
    send_item(8'sd0, 1'b1);
    send_item(8'sd64, 1'b0);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (seg = 0; seg < 8; seg++) begin
        drain();
        if (phase == 0 && seg == 0) begin
          load_config(-128, -128, 0, -32, 0, -32);
        end else if (phase == 0 && seg == 1) begin
          load_config(127, 127, 32767, 31, 32767, 31);
        end else if (phase == 1 && seg == 0) begin
          load_config(-128, 127, 32767, -31, 32767, 15);
        end else begin
          load_config(int'($urandom_range(255)) - 128, int'($urandom_range(255)) - 128,
                      int'($urandom_range(32767)), pick_shift(),
                      int'($urandom_range(32767)), pick_shift());
        end
        if (phase == 2 && seg == 0) begin
          // Long receiver stall while the sender keeps pushing items.
          @(posedge clk);
          hold_request = 1'b1;
          @(negedge clk);
        end
        for (n = 0; n < ITEMS_PER_SETTING; n++) begin
          send_item(8'($urandom), 1'($urandom));
        end
      end
    end
    in_valid = 1'b0;

    while (sb.pending() != 0) @(negedge clk);
    repeat (hsw_pkg::NUM_STAGES + 3) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
    $display("Mismatches found");
    $finish;
  end

endmodule
